// ----- hdl/mcev_pkg.sv -----
// shared types, constants and edge tables for the marching cubes edge vertex unit
package mcev_pkg;

	localparam int GRID_DIM      = 256;
	localparam int FRACTION_BITS = 8;
	localparam int LEVEL_BITS    = 16;

	localparam int POS_W    = 8;
	localparam int COORD_W  = 16;
	localparam int EDGE_W   = 4;
	localparam int TOL_W    = 8;
	localparam int NUM_EDGES = 12;
	localparam int DIFF_W   = LEVEL_BITS + 1;
	localparam int MAG_W    = LEVEL_BITS;
	localparam int QUOT_W   = FRACTION_BITS + 1;
	localparam int REM_W    = MAG_W + FRACTION_BITS + 1;
	localparam int STEP_W   = $clog2(QUOT_W);
	localparam int POS_MAX  = GRID_DIM - 2;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = LEVEL_BITS;
	localparam logic [CFG_IDX_W-1:0] REG_ISO_LEVEL      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_NEAR_TOLERANCE = CFG_IDX_W'(1);

	localparam logic [QUOT_W-1:0] FRAC_ONE = QUOT_W'(1) << FRACTION_BITS;

	typedef logic signed [LEVEL_BITS-1:0] level_t;

	typedef struct packed {
		logic [POS_W-1:0] cube_z;
		logic [POS_W-1:0] cube_y;
		logic [POS_W-1:0] cube_x;
		logic [7:0]       corner_valid_mask;
		level_t [7:0]     corner_level;
	} cube_t;

	localparam int S_TDATA_W = ($bits(cube_t) + 7) / 8 * 8;

	typedef struct packed {
		logic [EDGE_W-1:0]  edge_number;
		logic [COORD_W-1:0] vertex_z;
		logic [COORD_W-1:0] vertex_y;
		logic [COORD_W-1:0] vertex_x;
	} vertex_t;

	localparam int M_TDATA_W = ($bits(vertex_t) + 7) / 8 * 8;

	typedef struct packed {
		logic             start;
		logic [MAG_W-1:0] num;
		logic [MAG_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

	// first corner of an edge
	function automatic logic [2:0] edge_c1(input logic [EDGE_W-1:0] e);
		logic [2:0] c;
		unique case (e)
			4'd0:    c = 3'd0;
			4'd1:    c = 3'd1;
			4'd2:    c = 3'd2;
			4'd3:    c = 3'd3;
			4'd4:    c = 3'd4;
			4'd5:    c = 3'd5;
			4'd6:    c = 3'd6;
			4'd7:    c = 3'd7;
			4'd8:    c = 3'd0;
			4'd9:    c = 3'd1;
			4'd10:   c = 3'd2;
			4'd11:   c = 3'd3;
			default: c = 3'd0;
		endcase
		return c;
	endfunction

	// second corner of an edge
	function automatic logic [2:0] edge_c2(input logic [EDGE_W-1:0] e);
		logic [2:0] c;
		unique case (e)
			4'd0:    c = 3'd1;
			4'd1:    c = 3'd2;
			4'd2:    c = 3'd3;
			4'd3:    c = 3'd0;
			4'd4:    c = 3'd5;
			4'd5:    c = 3'd6;
			4'd6:    c = 3'd7;
			4'd7:    c = 3'd4;
			4'd8:    c = 3'd4;
			4'd9:    c = 3'd5;
			4'd10:   c = 3'd6;
			4'd11:   c = 3'd7;
			default: c = 3'd0;
		endcase
		return c;
	endfunction

	// corner offset, bit 0 x, bit 1 y, bit 2 z
	function automatic logic [2:0] corner_off(input logic [2:0] c);
		logic [2:0] o;
		unique case (c)
			3'd0: o = 3'b000;
			3'd1: o = 3'b001;
			3'd2: o = 3'b011;
			3'd3: o = 3'b010;
			3'd4: o = 3'b100;
			3'd5: o = 3'b101;
			3'd6: o = 3'b111;
			3'd7: o = 3'b110;
		endcase
		return o;
	endfunction

endpackage

// ----- hdl/mcev_div.sv -----
// restoring divider for the interpolation fraction, one quotient bit per cycle
module mcev_div (
	input  logic               clk,
	input  logic               arst_n,
	input  mcev_pkg::div_req_t req,
	output mcev_pkg::div_rsp_t rsp
);
	import mcev_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [REM_W-1:0]  rem_q;
	logic [REM_W-1:0]  dsh_q;
	logic [QUOT_W-1:0] quot_q;
	logic              fits;

	assign fits = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(QUOT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - STEP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			// rounding: add half the divisor up front
			rem_q  <= (REM_W'(req.num) << FRACTION_BITS) + REM_W'(req.den >> 1);
			dsh_q  <= REM_W'(req.den) << FRACTION_BITS;
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[QUOT_W-2:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("divider done without a finished run");

endmodule

// ----- hdl/mcev_ctrl.sv -----
// sequencer: cube index, edge walk, snap tests and vertex position
module mcev_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  mcev_pkg::cube_t                 in_cube,
	input  mcev_pkg::level_t                surf_level,
	input  logic [mcev_pkg::TOL_W-1:0]      near_tolerance,
	output logic                            vtx_valid,
	input  logic                            vtx_take,
	output mcev_pkg::vertex_t               vtx,
	output logic                            vtx_last,
	output mcev_pkg::div_req_t              div_req,
	input  mcev_pkg::div_rsp_t              div_rsp
);
	import mcev_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_INDEX  = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DIFF   = 3'd3;
	localparam logic [2:0] ST_DECIDE = 3'd4;
	localparam logic [2:0] ST_DIV    = 3'd5;
	localparam logic [2:0] ST_EMIT   = 3'd6;

	logic [2:0]              state_q;
	cube_t                   cube_q;
	logic [NUM_EDGES-1:0]    edges_q;
	logic [EDGE_W-1:0]       edge_q;
	logic [QUOT_W-1:0]       frac_q;
	logic signed [DIFF_W-1:0] d1_q;
	logic signed [DIFF_W-1:0] d2_q;
	logic signed [DIFF_W-1:0] d21_q;

	logic                    accept;
	logic [7:0]              below_mask;
	logic [NUM_EDGES-1:0]    edges;
	logic                    outside;
	logic [NUM_EDGES-1:0]    edges_low;
	logic [EDGE_W-1:0]       edge_first;
	level_t                  v1;
	level_t                  v2;
	logic [MAG_W-1:0]        mag1;
	logic [MAG_W-1:0]        mag2;
	logic [MAG_W-1:0]        mag21;
	logic [MAG_W-1:0]        tol_ext;
	logic signed [DIFF_W-1:0] num_s;
	logic                    dec_start;
	logic [QUOT_W-1:0]       dec_frac;
	logic [2:0]              c1;
	logic [2:0]              c2;
	logic [2:0]              off1;
	logic [2:0]              off2;
	logic [COORD_W-1:0]      coord [3];
	logic [POS_W-1:0]        pos [3];

	function automatic logic [MAG_W-1:0] mag(input logic signed [DIFF_W-1:0] x);
		logic signed [DIFF_W-1:0] a;
		a = x[DIFF_W-1] ? -x : x;
		return a[MAG_W-1:0];
	endfunction

	assign accept   = in_valid && in_ready;
	assign in_ready = state_q == ST_IDLE;

	// cube index and crossed edges
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			below_mask[i] = cube_q.corner_valid_mask[i] &&
				($signed(cube_q.corner_level[i]) < surf_level);
		end
		for (int e = 0; e < NUM_EDGES; e++) begin
			edges[e] = below_mask[edge_c1(EDGE_W'(e))] ^ below_mask[edge_c2(EDGE_W'(e))];
		end
		outside = (32'(cube_q.cube_x) > 32'(POS_MAX)) ||
			(32'(cube_q.cube_y) > 32'(POS_MAX)) ||
			(32'(cube_q.cube_z) > 32'(POS_MAX));
	end

	// lowest remaining edge
	always_comb begin
		edges_low  = edges_q & (~edges_q + NUM_EDGES'(1));
		edge_first = '0;
		for (int e = 0; e < NUM_EDGES; e++) begin
			if (edges_low[e]) begin
				edge_first = EDGE_W'(e);
			end
		end
	end

	assign c1   = edge_c1(edge_q);
	assign c2   = edge_c2(edge_q);
	assign v1   = cube_q.corner_level[c1];
	assign v2   = cube_q.corner_level[c2];
	assign off1 = corner_off(c1);
	assign off2 = corner_off(c2);

	// snap tests and saturation
	always_comb begin
		mag1      = mag(d1_q);
		mag2      = mag(d2_q);
		mag21     = mag(d21_q);
		tol_ext   = MAG_W'(near_tolerance);
		num_s     = d21_q[DIFF_W-1] ? -d1_q : d1_q;
		dec_start = 1'b0;
		dec_frac  = '0;
		priority if (mag1 < tol_ext) begin
			dec_frac = '0;
		end else if (mag2 < tol_ext) begin
			dec_frac = FRAC_ONE;
		end else if (mag21 < tol_ext || d21_q == '0) begin
			dec_frac = '0;
		end else if (num_s[DIFF_W-1] || num_s == '0) begin
			dec_frac = '0;
		end else if (num_s[MAG_W-1:0] >= mag21) begin
			dec_frac = FRAC_ONE;
		end else begin
			dec_start = 1'b1;
		end
	end

	assign div_req.start = state_q == ST_DECIDE && dec_start;
	assign div_req.num   = num_s[MAG_W-1:0];
	assign div_req.den   = mag21;

	// vertex position
	assign pos[0] = cube_q.cube_x;
	assign pos[1] = cube_q.cube_y;
	assign pos[2] = cube_q.cube_z;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			coord[a] = (COORD_W'(pos[a]) + COORD_W'(off1[a])) << FRACTION_BITS;
			if (off2[a] && !off1[a]) begin
				coord[a] = coord[a] + COORD_W'(frac_q);
			end else if (!off2[a] && off1[a]) begin
				coord[a] = coord[a] - COORD_W'(frac_q);
			end
		end
	end

	assign vtx_valid       = state_q == ST_EMIT;
	assign vtx_last        = edges_q == '0;
	assign vtx.vertex_x    = coord[0];
	assign vtx.vertex_y    = coord[1];
	assign vtx.vertex_z    = coord[2];
	assign vtx.edge_number = edge_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			edges_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_INDEX;
					end
				end
				ST_INDEX: begin
					edges_q <= edges;
					if (outside || edges == '0) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					edges_q <= edges_q & ~edges_low;
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					state_q <= dec_start ? ST_DIV : ST_EMIT;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (vtx_take) begin
						state_q <= (edges_q == '0) ? ST_IDLE : ST_SCAN;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cube_q <= in_cube;
		end
		if (state_q == ST_SCAN) begin
			edge_q <= edge_first;
		end
		if (state_q == ST_DIFF) begin
			d1_q  <= DIFF_W'(surf_level) - DIFF_W'(v1);
			d2_q  <= DIFF_W'(surf_level) - DIFF_W'(v2);
			d21_q <= DIFF_W'(v2) - DIFF_W'(v1);
		end
		if (state_q == ST_DECIDE) begin
			frac_q <= dec_frac;
		end else if (state_q == ST_DIV && div_rsp.done) begin
			frac_q <= (div_rsp.quot > FRAC_ONE) ? FRAC_ONE : div_rsp.quot;
		end
	end

	a_accept_index: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_INDEX)
		else $error("accepted cube not indexed");

	a_emit_edge: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid |-> edge_q < EDGE_W'(NUM_EDGES))
		else $error("vertex on a nonexistent edge");

	a_div_running: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && !div_rsp.done |-> div_rsp.busy)
		else $error("waiting on an idle divider");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid |-> frac_q <= FRAC_ONE)
		else $error("fraction above one");

endmodule

// ----- hdl/marching_cubes_edge_vertices_unit.sv -----
// top level: config registers, output word register, sequencer and divider
//
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata: corner0..7_level, mask, cube_x/y/z
// m_axis    out  m_axis_tvalid/tready       tdata: vertex_x/y/z, edge_number; tlast
// cfg       in   cfg_we (no wait)           cfg_index, cfg_data
//
// a cube is indexed first, then each crossed edge is scanned, differenced and decided;
// the vertex snaps to a corner or saturates, or goes through the divider (9 quotient steps)
// a cube outside the grid or with no crossing gives no word
// reset clears the sequencer, the divider and the output valid; surface level 0, tolerance 1
// a stalled m_axis holds the last vertex in the output register; the sequencer waits at
// the next vertex, and s_axis is ready again once the last vertex is handed over
module marching_cubes_edge_vertices_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// corner0_level .. corner7_level, corner_valid_mask, cube_x, cube_y, cube_z
	input  logic [mcev_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// vertex_x, vertex_y, vertex_z, edge_number, zero fill
	output logic [mcev_pkg::M_TDATA_W-1:0]     m_axis_tdata,
	output logic                               m_axis_tlast,
	input  logic                               cfg_we,
	input  logic [mcev_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mcev_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import mcev_pkg::*;

	level_t           surf_level_q;
	logic [TOL_W-1:0] near_tolerance_q;
	logic             out_valid_q;
	vertex_t          out_word_q;
	logic             out_last_q;

	cube_t    in_cube;
	vertex_t  vtx;
	logic     vtx_valid;
	logic     vtx_last;
	logic     vtx_take;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign in_cube  = cube_t'(s_axis_tdata[$bits(cube_t)-1:0]);
	assign vtx_take = vtx_valid && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			surf_level_q     <= '0;
			near_tolerance_q <= TOL_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ISO_LEVEL:      surf_level_q     <= level_t'(cfg_data);
				REG_NEAR_TOLERANCE: near_tolerance_q <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (vtx_take) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (vtx_take) begin
			out_word_q <= vtx;
			out_last_q <= vtx_last;
		end
	end

	mcev_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.in_cube        (in_cube),
		.surf_level     (surf_level_q),
		.near_tolerance (near_tolerance_q),
		.vtx_valid      (vtx_valid),
		.vtx_take       (vtx_take),
		.vtx            (vtx),
		.vtx_last       (vtx_last),
		.div_req        (div_req),
		.div_rsp        (div_rsp)
	);

	mcev_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = M_TDATA_W'(out_word_q);
	assign m_axis_tlast  = out_last_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |-> !vtx_take)
		else $error("output word overwritten while stalled");

	a_ready_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !vtx_valid && !div_rsp.busy)
		else $error("input ready while a cube is in work");

	a_last_ends_cube: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_take && vtx_last |=> s_axis_tready)
		else $error("sequencer still busy after the last vertex");

endmodule
